// ===== sv/top_k_score_selector_assert.svh =====
// ----------------------------------------------------------------------------
// top_k_score_selector_assert.svh
// Assertion macros used by the top-k selector checker (tks_checker).
// ----------------------------------------------------------------------------
`ifndef TOP_K_SCORE_SELECTOR_ASSERT_SVH
`define TOP_K_SCORE_SELECTOR_ASSERT_SVH

// same-cycle implication
`define TKS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: implication violated");

// next-cycle implication
`define TKS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication violated");

`endif

// ===== sv/tks_pkg.sv =====
// ----------------------------------------------------------------------------
// tks_pkg
// Constants and types for the top-k score selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tks_pkg;

  localparam int unsigned MAX_KEEP      = 64;
  localparam int unsigned CHUNK_ID_BITS = 8;
  localparam int unsigned KEEP_RESET    = 10;
  localparam int unsigned CFG_W         = 7;
  localparam int unsigned SCORE_W       = 32;
  localparam int unsigned DOC_W         = 32;

  localparam logic CMD_PUSH    = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } tks_state_e;

  typedef struct packed {
    logic insert;
    logic drain;
  } tks_cell_op_t;

endpackage

// ===== sv/tks_intf.sv =====
// ----------------------------------------------------------------------------
// tks_intf
// Valid/ready channels of the top-k selector: match in, result out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tks_in_if #(
  parameter int unsigned ChunkIdBits = tks_pkg::CHUNK_ID_BITS
);
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic [ChunkIdBits-1:0]          chunk_no;
  logic [tks_pkg::DOC_W-1:0]       doc_id;
  logic signed [tks_pkg::SCORE_W-1:0] score;

  modport source (output valid, cmd, chunk_no, doc_id, score, input ready);
  modport sink   (input valid, cmd, chunk_no, doc_id, score, output ready);
endinterface

interface tks_out_if #(
  parameter int unsigned ChunkIdBits = tks_pkg::CHUNK_ID_BITS
);
  logic                            valid;
  logic                            ready;
  logic [ChunkIdBits-1:0]          out_chunk_id;
  logic [tks_pkg::DOC_W-1:0]       out_doc_id;
  logic signed [tks_pkg::SCORE_W-1:0] out_score;
  logic                            last;

  modport source (output valid, out_chunk_id, out_doc_id, out_score, last, input ready);
  modport sink   (input valid, out_chunk_id, out_doc_id, out_score, last, output ready);
endinterface

// ===== sv/tks_cell.sv =====
// ----------------------------------------------------------------------------
// tks_cell
// One slot of the sorted chain: holds a match, shifts down on insert
// and up on drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tks_cell #(
  parameter int unsigned ChunkIdBits = tks_pkg::CHUNK_ID_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tks_pkg::tks_cell_op_t               op_i,
  input  logic                                enable_i,
  input  logic [ChunkIdBits-1:0]              new_chunk_i,
  input  logic [tks_pkg::DOC_W-1:0]           new_doc_i,
  input  logic signed [tks_pkg::SCORE_W-1:0]  new_score_i,
  input  logic                                prev_lt_i,
  input  logic                                prev_valid_i,
  input  logic [ChunkIdBits-1:0]              prev_chunk_i,
  input  logic [tks_pkg::DOC_W-1:0]           prev_doc_i,
  input  logic signed [tks_pkg::SCORE_W-1:0]  prev_score_i,
  input  logic                                next_valid_i,
  input  logic [ChunkIdBits-1:0]              next_chunk_i,
  input  logic [tks_pkg::DOC_W-1:0]           next_doc_i,
  input  logic signed [tks_pkg::SCORE_W-1:0]  next_score_i,
  output logic                                lt_o,
  output logic                                valid_o,
  output logic [ChunkIdBits-1:0]              chunk_o,
  output logic [tks_pkg::DOC_W-1:0]           doc_o,
  output logic signed [tks_pkg::SCORE_W-1:0]  score_o
);
  import tks_pkg::*;

  logic                      valid_q, valid_d;
  logic [ChunkIdBits-1:0]    chunk_q, chunk_d;
  logic [DOC_W-1:0]          doc_q, doc_d;
  logic signed [SCORE_W-1:0] score_q, score_d;
  logic                      load;

  // empty slot ranks below anything; equal score stays ahead
  assign lt_o = !valid_q || (score_q < new_score_i);

  always_comb begin
    valid_d = valid_q;
    chunk_d = chunk_q;
    doc_d   = doc_q;
    score_d = score_q;
    load    = 1'b0;
    if (op_i.insert && enable_i && lt_o) begin
      load = 1'b1;
      if (prev_lt_i) begin
        valid_d = prev_valid_i;
        chunk_d = prev_chunk_i;
        doc_d   = prev_doc_i;
        score_d = prev_score_i;
      end else begin
        valid_d = 1'b1;
        chunk_d = new_chunk_i;
        doc_d   = new_doc_i;
        score_d = new_score_i;
      end
    end else if (op_i.drain) begin
      load    = 1'b1;
      valid_d = next_valid_i;
      chunk_d = next_chunk_i;
      doc_d   = next_doc_i;
      score_d = next_score_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      chunk_q <= chunk_d;
      doc_q   <= doc_d;
      score_q <= score_d;
    end
  end

  assign valid_o = valid_q;
  assign chunk_o = chunk_q;
  assign doc_o   = doc_q;
  assign score_o = score_q;

endmodule

// ===== sv/top_k_score_selector.sv =====
// ----------------------------------------------------------------------------
// top_k_score_selector
// Keeps the best keep_count matches in a sorted register chain and emits
// them in descending score order on extract.
// ----------------------------------------------------------------------------
// Channel    Dir  Payload                                    Word
// match_i    in   cmd, chunk_no, doc_id, score               one push/extract
// result_o   out  out_chunk_id, out_doc_id, out_score, last  one held match
// cfg        in   cfg_we_i, cfg_wdata_i (keep_count)         one register
//
// Push: every cell compares against the broadcast score at once.
// Extract: accepted in ST_IDLE, then one held match per cycle leaves through the
// chain head in ST_DRAIN, paced by result_o.ready; an empty extract gives no output.
// match_i.ready is low while a drain runs.
// Reset clears the cell valid bits and sets keep_count to 10; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module top_k_score_selector #(
  parameter int unsigned MaxKeep     = tks_pkg::MAX_KEEP,
  parameter int unsigned ChunkIdBits = tks_pkg::CHUNK_ID_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tks_in_if.sink                      match_i,
  tks_out_if.source                   result_o,
  input  logic                        cfg_we_i,
  input  logic [tks_pkg::CFG_W-1:0]   cfg_wdata_i
);
  import tks_pkg::*;

  localparam int unsigned KeepW     = $clog2(MaxKeep + 1);
  localparam int unsigned CmpW      = (KeepW > CFG_W) ? KeepW : CFG_W;
  localparam int unsigned KeepReset = (KEEP_RESET > MaxKeep) ? MaxKeep : KEEP_RESET;

  tks_state_e state_q, state_d;
  tks_cell_op_t op;

  logic [KeepW-1:0] keep_q, keep_d;
  logic [CmpW-1:0]  cfg_wide;

  logic                      cv    [MaxKeep+1];
  logic [ChunkIdBits-1:0]    cchunk[MaxKeep+1];
  logic [DOC_W-1:0]          cdoc  [MaxKeep+1];
  logic signed [SCORE_W-1:0] cscore[MaxKeep+1];
  logic                      clt   [MaxKeep];

  logic                      out_valid_q;
  logic [ChunkIdBits-1:0]    out_chunk_q;
  logic [DOC_W-1:0]          out_doc_q;
  logic signed [SCORE_W-1:0] out_score_q;
  logic                      out_last_q;
  logic                      slot_free;
  logic                      out_load;
  logic                      out_last_d;

  // past-the-end neighbor of the last cell
  assign cv[MaxKeep]     = 1'b0;
  assign cchunk[MaxKeep] = '0;
  assign cdoc[MaxKeep]   = '0;
  assign cscore[MaxKeep] = '0;

  for (genvar g = 0; g < MaxKeep; g++) begin : g_cell
    logic                      p_lt;
    logic                      p_valid;
    logic [ChunkIdBits-1:0]    p_chunk;
    logic [DOC_W-1:0]          p_doc;
    logic signed [SCORE_W-1:0] p_score;

    if (g == 0) begin : g_head
      assign p_lt    = 1'b0;
      assign p_valid = 1'b0;
      assign p_chunk = '0;
      assign p_doc   = '0;
      assign p_score = '0;
    end else begin : g_body
      assign p_lt    = clt[g-1];
      assign p_valid = cv[g-1];
      assign p_chunk = cchunk[g-1];
      assign p_doc   = cdoc[g-1];
      assign p_score = cscore[g-1];
    end

    tks_cell #(
      .ChunkIdBits(ChunkIdBits)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op),
      .enable_i    (keep_q > KeepW'(g)),
      .new_chunk_i (match_i.chunk_no),
      .new_doc_i   (match_i.doc_id),
      .new_score_i (match_i.score),
      .prev_lt_i   (p_lt),
      .prev_valid_i(p_valid),
      .prev_chunk_i(p_chunk),
      .prev_doc_i  (p_doc),
      .prev_score_i(p_score),
      .next_valid_i(cv[g+1]),
      .next_chunk_i(cchunk[g+1]),
      .next_doc_i  (cdoc[g+1]),
      .next_score_i(cscore[g+1]),
      .lt_o        (clt[g]),
      .valid_o     (cv[g]),
      .chunk_o     (cchunk[g]),
      .doc_o       (cdoc[g]),
      .score_o     (cscore[g])
    );
  end

  assign slot_free  = !out_valid_q || result_o.ready;
  assign out_last_d = !cv[1];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (match_i.valid && match_i.cmd == CMD_EXTRACT) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!cv[0]) begin
          state_d = ST_IDLE;
        end else if (slot_free && out_last_d) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    match_i.ready = 1'b0;
    op            = '0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        match_i.ready = 1'b1;
        op.insert     = match_i.valid && (match_i.cmd == CMD_PUSH);
      end
      ST_DRAIN: begin
        out_load = cv[0] && slot_free;
        op.drain = out_load;
      end
      default: ;
    endcase
  end

  always_comb begin
    cfg_wide = CmpW'(cfg_wdata_i);
    keep_d   = keep_q;
    if (cfg_we_i && !cv[0]) begin
      if (cfg_wide == '0) begin
        keep_d = KeepW'(1);
      end else if (cfg_wide > CmpW'(MaxKeep)) begin
        keep_d = KeepW'(MaxKeep);
      end else begin
        keep_d = KeepW'(cfg_wide);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      keep_q      <= KeepW'(KeepReset);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      keep_q  <= keep_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_chunk_q <= cchunk[0];
      out_doc_q   <= cdoc[0];
      out_score_q <= cscore[0];
      out_last_q  <= out_last_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.out_chunk_id = out_chunk_q;
  assign result_o.out_doc_id   = out_doc_q;
  assign result_o.out_score    = out_score_q;
  assign result_o.last         = out_last_q;

endmodule

// ===== sv/tks_checker.sv =====
// ----------------------------------------------------------------------------
// tks_checker
// Port-level checks of the top-k selector, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "top_k_score_selector_assert.svh"

module tks_checker #(
  parameter int unsigned ChunkIdBits = tks_pkg::CHUNK_ID_BITS
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               in_cmd_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [ChunkIdBits-1:0]             out_chunk_i,
  input logic [tks_pkg::DOC_W-1:0]          out_doc_i,
  input logic signed [tks_pkg::SCORE_W-1:0] out_score_i,
  input logic                               out_last_i
);
  import tks_pkg::*;

  `TKS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_chunk_i) && $stable(out_doc_i) && $stable(out_score_i) && $stable(out_last_i))
  `TKS_ASSERT_NEXT(a_extract_blocks, clk_i, rst_ni, in_valid_i && in_ready_i && in_cmd_i == CMD_EXTRACT, !in_ready_i)
  `TKS_ASSERT_IMPL(a_mid_run_busy, clk_i, rst_ni, out_valid_i && !out_last_i, !in_ready_i)
  `TKS_ASSERT_IMPL(a_out_from_drain, clk_i, rst_ni, $rose(out_valid_i), $past(!in_ready_i))

endmodule

bind top_k_score_selector tks_checker #(
  .ChunkIdBits(ChunkIdBits)
) u_tks_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (match_i.valid),
  .in_ready_i (match_i.ready),
  .in_cmd_i   (match_i.cmd),
  .out_valid_i(result_o.valid),
  .out_ready_i(result_o.ready),
  .out_chunk_i(result_o.out_chunk_id),
  .out_doc_i  (result_o.out_doc_id),
  .out_score_i(result_o.out_score),
  .out_last_i (result_o.last)
);
